/* hw/rtl/tsr_pkg.sv */
// ----------------------------------------------------------------------------
// tsr_pkg
// Shared types and codes of the top-K score ranking store.
// ----------------------------------------------------------------------------
package tsr_pkg;

  // Widths of the fixed item fields.
  localparam int DOC_W   = 32;
  localparam int SCORE_W = 32;
  localparam int TERMS_W = 4;
  localparam int RANK_W  = 4;
  localparam int REQ_W   = 2;
  localparam int LIMIT_W = 5;

  // Value of the kept-count limit after reset.
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd10;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ   = 2'd2;

  // One kept document.
  typedef struct packed {
    logic [DOC_W-1:0]   doc_id;
    logic [SCORE_W-1:0] score;
    logic [TERMS_W-1:0] terms;
  } entry_t;

  // Ordering key of one entry, without its store index.
  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [DOC_W-1:0]   doc_id;
  } rank_key_t;

endpackage

/* hw/rtl/topk_score_ranking.sv */
// ----------------------------------------------------------------------------
// topk_score_ranking
// Keeps the best K documents of a query with a rising admission threshold.
// ----------------------------------------------------------------------------
// One item is worked at a time; the input stalls until its result has been
// loaded into the output register, and the next item is taken while that
// result still waits. All work runs through one entry memory read port and
// one ranking comparator under a small sequencer: a clear, a rejected insert
// or an insert below K goes straight to the output hand-off; an insert that
// fills the store scans the held entries once for the new threshold; an
// insert into a full store scans once to find the worst entry and once more
// for the new minimum; a read of rank r walks candidates in store order and
// counts, for each, the entries ahead of it. A result that waits in the
// output register holds the sequencer before its next load.
// ----------------------------------------------------------------------------
module topk_score_ranking
  import tsr_pkg::*;
#(
  parameter int MAX_ENTRIES = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Configuration
  input  logic                                 cfg_wr_en,
  input  logic [LIMIT_W-1:0]                   cfg_wr_data,
  // Request channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [REQ_W-1:0]                     in_req_type,
  input  logic [DOC_W-1:0]                     in_doc_id,
  input  logic [SCORE_W-1:0]                   in_score,
  input  logic [TERMS_W-1:0]                   in_term_count,
  input  logic [RANK_W-1:0]                    in_read_rank,
  // Result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_accepted,
  output logic [SCORE_W-1:0]                   out_threshold,
  output logic [$clog2(MAX_ENTRIES+1)-1:0]     out_fill_count,
  output logic                                 out_entry_valid,
  output logic [DOC_W-1:0]                     out_entry_doc_id,
  output logic [SCORE_W-1:0]                   out_entry_score,
  output logic [TERMS_W-1:0]                   out_entry_terms
);

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int AW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CMP_W = (CNT_W > RANK_W) ? CNT_W : RANK_W;
  localparam int LW    = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_FIND   = 6'b000010,
    S_MIN    = 6'b000100,
    S_RD_SEL = 6'b001000,
    S_RD_CNT = 6'b010000,
    S_PUT    = 6'b100000
  } state_t;

  // Control state
  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     held_r, held_nxt;
  logic [SCORE_W-1:0]   thr_r, thr_nxt;
  logic [LIMIT_W-1:0]   limit_r;
  logic                 pend_r, pend_nxt;
  logic                 out_valid_r, out_valid_nxt;

  // Working registers
  entry_t               cand_r, cand_nxt;
  logic [RANK_W-1:0]    rank_r, rank_nxt;
  logic                 acc_r, acc_nxt;
  logic                 ent_valid_r, ent_valid_nxt;
  logic [CNT_W-1:0]     scan_cnt_r, scan_cnt_nxt;
  logic [AW-1:0]        pidx_r, pidx_nxt;
  logic [CNT_W-1:0]     idx_r, idx_nxt;
  logic [CMP_W-1:0]     ahead_r, ahead_nxt;
  entry_t               worst_r, worst_nxt;
  logic [AW-1:0]        worst_idx_r, worst_idx_nxt;

  // Output payload registers
  logic                 o_acc_r;
  logic [SCORE_W-1:0]   o_thr_r;
  logic [CNT_W-1:0]     o_fill_r;
  logic                 o_valid_ent_r;
  entry_t               o_ent_r;
  logic                 out_load;

  // Memory and comparator connections
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  entry_t               mem_wdata;
  logic [AW-1:0]        mem_raddr;
  entry_t               mem_rdata;
  rank_key_t            cmp_a_key, cmp_b_key;
  logic [AW-1:0]        cmp_a_idx, cmp_b_idx;
  logic                 cmp_ahead;

  logic [LW-1:0]        limit_ext;
  logic [CNT_W-1:0]     keep_k;
  logic                 scan_issue;
  logic                 scan_done;

  // Effective K: zero counts as one, values past the depth as the depth.
  always_comb begin
    limit_ext = LW'(limit_r);
    if (limit_r == '0) begin
      keep_k = CNT_W'(1);
    end else if (limit_ext > LW'(MAX_ENTRIES)) begin
      keep_k = CNT_W'(MAX_ENTRIES);
    end else begin
      keep_k = limit_ext[CNT_W-1:0];
    end
  end

  tsr_store #(
    .DEPTH (MAX_ENTRIES),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  // The comparator checks the worst-so-far against the streamed entry in the
  // worst scans, and the streamed entry against the candidate while counting.
  always_comb begin
    if (state_r == S_RD_CNT) begin
      cmp_a_key = '{score: mem_rdata.score, doc_id: mem_rdata.doc_id};
      cmp_a_idx = pidx_r;
      cmp_b_key = '{score: cand_r.score, doc_id: cand_r.doc_id};
      cmp_b_idx = idx_r[AW-1:0];
    end else begin
      cmp_a_key = '{score: worst_r.score, doc_id: worst_r.doc_id};
      cmp_a_idx = worst_idx_r;
      cmp_b_key = '{score: mem_rdata.score, doc_id: mem_rdata.doc_id};
      cmp_b_idx = pidx_r;
    end
  end

  tsr_rank_cmp #(
    .AW (AW)
  ) u_cmp (
    .a_key   (cmp_a_key),
    .a_idx   (cmp_a_idx),
    .b_key   (cmp_b_key),
    .b_idx   (cmp_b_idx),
    .a_ahead (cmp_ahead)
  );

  assign in_stall   = (state_r != S_IDLE);
  assign scan_issue = (scan_cnt_r < held_r);
  assign scan_done  = !scan_issue && !pend_r;

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    held_nxt      = held_r;
    thr_nxt       = thr_r;
    cand_nxt      = cand_r;
    rank_nxt      = rank_r;
    acc_nxt       = acc_r;
    ent_valid_nxt = ent_valid_r;
    scan_cnt_nxt  = scan_cnt_r;
    pend_nxt      = 1'b0;
    pidx_nxt      = scan_cnt_r[AW-1:0];
    idx_nxt       = idx_r;
    ahead_nxt     = ahead_r;
    worst_nxt     = worst_r;
    worst_idx_nxt = worst_idx_r;
    mem_we        = 1'b0;
    mem_waddr     = worst_idx_r;
    mem_wdata     = cand_r;
    mem_raddr     = scan_cnt_r[AW-1:0];
    out_load      = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cand_nxt      = '{doc_id: in_doc_id, score: in_score, terms: in_term_count};
          rank_nxt      = in_read_rank;
          acc_nxt       = 1'b0;
          ent_valid_nxt = 1'b0;
          scan_cnt_nxt  = '0;
          state_nxt     = S_PUT;
          unique case (in_req_type)
            REQ_INSERT: begin
              if (in_score >= thr_r) begin
                acc_nxt = 1'b1;
                if (held_r < keep_k) begin
                  // Room left: append at the fill position.
                  mem_we    = 1'b1;
                  mem_waddr = held_r[AW-1:0];
                  mem_wdata = '{doc_id: in_doc_id, score: in_score, terms: in_term_count};
                  held_nxt  = held_r + CNT_W'(1);
                  if (held_r + CNT_W'(1) >= keep_k) begin
                    state_nxt = S_MIN;
                  end
                end else begin
                  state_nxt = S_FIND;
                end
              end
            end
            REQ_CLEAR: begin
              held_nxt = '0;
              thr_nxt  = '0;
            end
            REQ_READ: begin
              if (held_r != '0) begin
                idx_nxt   = '0;
                state_nxt = S_RD_SEL;
              end
            end
            default: begin
              state_nxt = S_PUT;
            end
          endcase
        end
      end

      S_FIND, S_MIN: begin
        // Stream the held entries and keep the worst one seen.
        if (scan_issue) begin
          scan_cnt_nxt = scan_cnt_r + CNT_W'(1);
          pend_nxt     = 1'b1;
        end
        if (pend_r && ((pidx_r == '0) || cmp_ahead)) begin
          worst_nxt     = mem_rdata;
          worst_idx_nxt = pidx_r;
        end
        if (scan_done) begin
          if (state_r == S_FIND) begin
            // Replace the worst entry, then rescan for the new minimum.
            mem_we       = 1'b1;
            scan_cnt_nxt = '0;
            state_nxt    = S_MIN;
          end else begin
            if (worst_r.score > thr_r) begin
              thr_nxt = worst_r.score;
            end
            state_nxt = S_PUT;
          end
        end
      end

      S_RD_SEL: begin
        // Fetch the next candidate for the requested rank.
        mem_raddr = idx_r[AW-1:0];
        if (!pend_r) begin
          pend_nxt = 1'b1;
        end else begin
          cand_nxt     = mem_rdata;
          ahead_nxt    = '0;
          scan_cnt_nxt = '0;
          state_nxt    = S_RD_CNT;
        end
      end

      S_RD_CNT: begin
        // Count the entries that rank ahead of the candidate.
        if (scan_issue) begin
          scan_cnt_nxt = scan_cnt_r + CNT_W'(1);
          pend_nxt     = 1'b1;
        end
        if (pend_r && cmp_ahead) begin
          ahead_nxt = ahead_r + CMP_W'(1);
        end
        if (scan_done) begin
          if (ahead_r == CMP_W'(rank_r)) begin
            ent_valid_nxt = 1'b1;
            state_nxt     = S_PUT;
          end else if (idx_r + CNT_W'(1) >= held_r) begin
            state_nxt = S_PUT;
          end else begin
            idx_nxt   = idx_r + CNT_W'(1);
            state_nxt = S_RD_SEL;
          end
        end
      end

      S_PUT: begin
        // Hand the result to the output register once it is free.
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register valid: cleared by a transfer, set by a new result.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      held_r      <= '0;
      thr_r       <= '0;
      limit_r     <= LIMIT_RESET;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      held_r      <= held_nxt;
      thr_r       <= thr_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    cand_r      <= cand_nxt;
    rank_r      <= rank_nxt;
    acc_r       <= acc_nxt;
    ent_valid_r <= ent_valid_nxt;
    scan_cnt_r  <= scan_cnt_nxt;
    pidx_r      <= pidx_nxt;
    idx_r       <= idx_nxt;
    ahead_r     <= ahead_nxt;
    worst_r     <= worst_nxt;
    worst_idx_r <= worst_idx_nxt;
  end

  // Output payload; entry fields are zero unless a read found its rank.
  always_ff @(posedge clk) begin
    if (out_load) begin
      o_acc_r       <= acc_r;
      o_thr_r       <= thr_r;
      o_fill_r      <= held_r;
      o_valid_ent_r <= ent_valid_r;
      o_ent_r       <= ent_valid_r ? cand_r : '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_accepted     = o_acc_r;
  assign out_threshold    = o_thr_r;
  assign out_fill_count   = o_fill_r;
  assign out_entry_valid  = o_valid_ent_r;
  assign out_entry_doc_id = o_ent_r.doc_id;
  assign out_entry_score  = o_ent_r.score;
  assign out_entry_terms  = o_ent_r.terms;

endmodule

/* hw/rtl/tsr_store.sv */
// ----------------------------------------------------------------------------
// tsr_store
// Entry memory: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tsr_store
  import tsr_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  entry_t        wr_data,
  input  logic [AW-1:0] rd_addr,
  output entry_t        rd_data
);

  entry_t mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

/* hw/rtl/tsr_rank_cmp.sv */
// ----------------------------------------------------------------------------
// tsr_rank_cmp
// Ranking compare: higher score first, then smaller document id, then
// smaller store index.
// ----------------------------------------------------------------------------
module tsr_rank_cmp
  import tsr_pkg::*;
#(
  parameter int AW = 4
) (
  input  rank_key_t     a_key,
  input  logic [AW-1:0] a_idx,
  input  rank_key_t     b_key,
  input  logic [AW-1:0] b_idx,
  output logic          a_ahead
);

  // True when entry a ranks strictly ahead of entry b.
  always_comb begin
    if (a_key.score != b_key.score) begin
      a_ahead = (a_key.score > b_key.score);
    end else if (a_key.doc_id != b_key.doc_id) begin
      a_ahead = (a_key.doc_id < b_key.doc_id);
    end else begin
      a_ahead = (a_idx < b_idx);
    end
  end

endmodule
